// ----- rtl/segt_pkg.sv -----
package segt_pkg;

  localparam int unsigned LEAVES_DEF = 1024;

  localparam int unsigned CFG_W  = 11;
  localparam int unsigned POS_W  = 10;
  localparam int unsigned END_W  = 11;
  localparam int unsigned DATA_W = 32;

  localparam logic [CFG_W-1:0] LEAVES_RESET = 11'd1024;

  localparam logic CMD_SET   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic clr_wr;    // write zero at the clear pointer
    logic load;      // capture a new command word
    logic set_leaf;  // write the leaf, fetch its sibling
    logic set_step;  // write one parent, fetch next sibling
    logic qry_step;  // fetch one level of the query, fold last level
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic err;
    logic is_query;
    logic k_is_one;
    logic kn_is_one;
    logic qry_done;
  } dpath_stat_t;

endpackage

// ----- rtl/segt_ctrl.sv -----
module segt_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  input  segt_pkg::dpath_stat_t    stat_i,
  output logic                     busy,
  output logic                     done_o,
  output segt_pkg::ctrl_cmd_t      cmd_o
);
  import segt_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_SET_WALK,
    ST_QRY_WALK
  } state_e;

  state_e state_q;
  logic   done_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.clr_wr   = (state_q == ST_CLEAR);
    cmd_o.load     = (state_q == ST_IDLE) && start;
    cmd_o.set_leaf = (state_q == ST_CHECK) && !stat_i.err && !stat_i.is_query;
    cmd_o.set_step = (state_q == ST_SET_WALK);
    cmd_o.qry_step = (state_q == ST_QRY_WALK);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_CLEAR: begin
          if (stat_i.clr_last) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (stat_i.err) begin
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else if (stat_i.is_query) begin
            state_q <= ST_QRY_WALK;
          end else if (stat_i.k_is_one) begin
            // single leaf: the leaf is the root
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_SET_WALK;
          end
        end
        ST_SET_WALK: begin
          if (stat_i.kn_is_one) begin
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        ST_QRY_WALK: begin
          if (stat_i.qry_done) begin
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

// ----- rtl/segt_dpath.sv -----
module segt_dpath #(
  parameter int unsigned LEAVES = segt_pkg::LEAVES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [segt_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                              cmd_i,
  input  logic [segt_pkg::POS_W-1:0]        position_i,
  input  logic [segt_pkg::END_W-1:0]        end_position_i,
  input  logic [segt_pkg::DATA_W-1:0]       leaf_value_i,
  input  segt_pkg::ctrl_cmd_t               cmd_ctl_i,
  output segt_pkg::dpath_stat_t             stat_o,
  output logic [segt_pkg::DATA_W-1:0]       range_sum_o,
  output logic                              error_o
);
  import segt_pkg::*;

  localparam int unsigned NODES = 2 * LEAVES;
  localparam int unsigned AW    = $clog2(NODES);
  localparam int unsigned HW    = AW + 1;

  logic [DATA_W-1:0] mem [NODES];

  logic [CFG_W-1:0]  cfg_q;
  logic [CFG_W-1:0]  n_w;
  logic [AW-1:0]     clr_cnt_q;
  logic [AW-1:0]     k_q;
  logic [AW-1:0]     kn;
  logic [HW-1:0]     lo_q, hi_q, lo_d, hi_d;
  logic [HW-1:0]     hi_m1;
  logic [DATA_W-1:0] cur_q, acc_q, acc_d, parent;
  logic [DATA_W-1:0] rd_a_q, rd_b_q;
  logic              mask_a_q, mask_b_q, mask_a_d, mask_b_d;
  logic              err_q, err_d, query_q, active;
  logic              we;
  logic [AW-1:0]     wa, ra, rb;
  logic [DATA_W-1:0] wd;

  // Clamp the leaf count to the store size
  always_comb begin
    if (32'(cfg_q) > LEAVES) begin
      n_w = CFG_W'(LEAVES);
    end else begin
      n_w = cfg_q;
    end
  end

  always_comb begin
    if (cmd_i == CMD_SET) begin
      err_d = ({1'b0, position_i} >= n_w);
    end else begin
      err_d = ({1'b0, position_i} > end_position_i) || (end_position_i > n_w);
    end
  end

  assign kn     = k_q >> 1;
  assign parent = cur_q + rd_a_q;

  // One level of the bottom-up query walk
  assign active   = (lo_q < hi_q);
  assign mask_a_d = active && lo_q[0];
  assign mask_b_d = active && hi_q[0];
  assign lo_d     = (lo_q + HW'(lo_q[0])) >> 1;
  assign hi_d     = (hi_q - HW'(hi_q[0])) >> 1;
  assign hi_m1    = hi_q - HW'(1);
  assign acc_d    = acc_q + (mask_a_q ? rd_a_q : '0) + (mask_b_q ? rd_b_q : '0);

  always_comb begin
    we = 1'b0;
    wa = k_q;
    wd = cur_q;
    if (cmd_ctl_i.clr_wr) begin
      we = 1'b1;
      wa = clr_cnt_q;
      wd = '0;
    end else if (cmd_ctl_i.set_leaf) begin
      we = 1'b1;
    end else if (cmd_ctl_i.set_step) begin
      we = 1'b1;
      wa = kn;
      wd = parent;
    end
  end

  always_comb begin
    if (cmd_ctl_i.set_leaf) begin
      ra = k_q ^ AW'(1);
    end else if (cmd_ctl_i.set_step) begin
      ra = kn ^ AW'(1);
    end else begin
      ra = lo_q[AW-1:0];
    end
  end

  assign rb = hi_m1[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a_q <= mem[ra];
    rd_b_q <= mem[rb];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q     <= LEAVES_RESET;
      clr_cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (cmd_ctl_i.clr_wr) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_ctl_i.load) begin
      k_q      <= AW'(position_i) + AW'(n_w);
      lo_q     <= HW'(position_i) + HW'(n_w);
      hi_q     <= HW'(end_position_i) + HW'(n_w);
      cur_q    <= leaf_value_i;
      acc_q    <= '0;
      mask_a_q <= 1'b0;
      mask_b_q <= 1'b0;
      err_q    <= err_d;
      query_q  <= (cmd_i == CMD_QUERY);
    end else if (cmd_ctl_i.set_step) begin
      k_q   <= kn;
      cur_q <= parent;
    end else if (cmd_ctl_i.qry_step) begin
      lo_q     <= lo_d;
      hi_q     <= hi_d;
      acc_q    <= acc_d;
      mask_a_q <= mask_a_d;
      mask_b_q <= mask_b_d;
    end
  end

  always_comb begin
    stat_o           = '0;
    stat_o.clr_last  = (clr_cnt_q == AW'(NODES - 1));
    stat_o.err       = err_q;
    stat_o.is_query  = query_q;
    stat_o.k_is_one  = (k_q == AW'(1));
    stat_o.kn_is_one = (kn == AW'(1));
    stat_o.qry_done  = !active;
  end

  assign range_sum_o = acc_q;
  assign error_o     = err_q;

endmodule

// ----- rtl/segment_tree_range_sum_unit.sv -----
// Range-sum segment tree over signed 32-bit leaves, stored bottom-up in a
// 2*LEAVES word memory with one write and two registered read ports. After
// reset the unit zeroes the whole store, one word a cycle, so busy stays high
// until the last word is cleared, and only then is the first command taken;
// configuration writes are taken during that pass. A command is taken when
// start is high and busy is low. A set walks from the leaf to the root, one
// level per cycle through the read port, and strobes once the root is
// written. A query reads both interval edges of one level per cycle and
// strobes once its interval is empty. A new command may be started in the
// strobe cycle. done_o is high for one cycle with range_sum_o and error_o;
// there is no backpressure, so capture the word in that cycle. An
// out-of-range command returns error_o high with a zero sum and leaves the
// store unchanged.
module segment_tree_range_sum_unit #(
  parameter int unsigned LEAVES = segt_pkg::LEAVES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [segt_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                              start,
  output logic                              busy,
  input  logic                              cmd_i,
  input  logic [segt_pkg::POS_W-1:0]        position_i,
  input  logic [segt_pkg::END_W-1:0]        end_position_i,
  input  logic signed [segt_pkg::DATA_W-1:0] leaf_value_i,
  output logic                              done_o,
  output logic signed [segt_pkg::DATA_W-1:0] range_sum_o,
  output logic                              error_o
);
  import segt_pkg::*;

  ctrl_cmd_t         cmd_ctl;
  dpath_stat_t       stat;
  logic [DATA_W-1:0] sum_w;

  segt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd_ctl)
  );

  segt_dpath #(
    .LEAVES (LEAVES)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (cmd_i),
    .position_i     (position_i),
    .end_position_i (end_position_i),
    .leaf_value_i   (leaf_value_i),
    .cmd_ctl_i      (cmd_ctl),
    .stat_o         (stat),
    .range_sum_o    (sum_w),
    .error_o        (error_o)
  );

  assign range_sum_o = sum_w;

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe lasted more than one cycle");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && error_o) |-> (range_sum_o == '0))
    else $error("rejected command returned a nonzero sum");
`endif

endmodule

// ----- test/segment_tree_range_sum_unit_tb.sv -----
module segment_tree_range_sum_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import segt_pkg::*;

  localparam int unsigned NODES       = 2 * LEAVES_DEF;
  localparam int unsigned SETTLE      = 20;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    logic              cmd;
    logic [POS_W-1:0]  pos;
    logic [END_W-1:0]  endp;
    logic [DATA_W-1:0] val;
  } tree_cmd_t;

  typedef struct {
    logic [DATA_W-1:0] sum;
    logic              err;
  } tree_result_t;

  logic                     clk_i          = 1'b0;
  logic                     rst_ni         = 1'b0;
  logic                     cfg_we_i       = 1'b0;
  logic [CFG_W-1:0]         cfg_wdata_i    = '0;
  logic                     start          = 1'b0;
  logic                     busy;
  logic                     cmd_i          = CMD_SET;
  logic [POS_W-1:0]         position_i     = '0;
  logic [END_W-1:0]         end_position_i = '0;
  logic signed [DATA_W-1:0] leaf_value_i   = '0;
  logic                     done_o;
  logic signed [DATA_W-1:0] range_sum_o;
  logic                     error_o;

  tree_cmd_t    pending_cmds[$];
  tree_result_t sum_expect_q[$];
  logic [DATA_W-1:0] tree_model [NODES];
  logic [CFG_W-1:0]  leaves_cfg;
  int unsigned       words_sent   = 0;
  int unsigned       mismatch_cnt = 0;
  int unsigned       cycle_cnt    = 0;

  segment_tree_range_sum_unit #(
    .LEAVES(LEAVES_DEF)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .position_i    (position_i),
    .end_position_i(end_position_i),
    .leaf_value_i  (leaf_value_i),
    .done_o        (done_o),
    .range_sum_o   (range_sum_o),
    .error_o       (error_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [DATA_W-1:0] node_rd(int unsigned k);
    return (k < NODES) ? tree_model[k] : '0;
  endfunction

  // Apply one command to the shadow tree and return the word it must produce.
  function automatic tree_result_t apply_tree_cmd(tree_cmd_t w);
    int unsigned  n;
    int unsigned  k;
    int unsigned  lo;
    int unsigned  hi;
    tree_result_t r;
    n = (leaves_cfg > LEAVES_DEF) ? LEAVES_DEF : leaves_cfg;
    r.sum = '0;
    r.err = 1'b0;
    if (w.cmd == CMD_SET) begin
      if (w.pos >= n) begin
        r.err = 1'b1;
      end else begin
        k = w.pos + n;
        if (k < NODES) tree_model[k] = w.val;
        while (k > 1) begin
          if ((k >> 1) < NODES) tree_model[k >> 1] = node_rd(k) + node_rd(k ^ 1);
          k = k >> 1;
        end
      end
    end else begin
      if (w.pos > w.endp || w.endp > n) begin
        r.err = 1'b1;
      end else begin
        lo = w.pos + n;
        hi = w.endp + n;
        while (lo < hi) begin
          if (lo[0]) begin
            r.sum = r.sum + node_rd(lo);
            lo = lo + 1;
          end
          if (hi[0]) begin
            hi = hi - 1;
            r.sum = r.sum + node_rd(hi);
          end
          lo = lo >> 1;
          hi = hi >> 1;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [DATA_W-1:0] got,
                                 logic [DATA_W-1:0] want);
    if (mismatch_cnt < 50)
      $display("%0t: %s got %h, want %h", $time, field, got, want);
    mismatch_cnt++;
  endtask

  task automatic add_cmd(logic cmd, int unsigned pos, int unsigned endp,
                         logic [DATA_W-1:0] val);
    tree_cmd_t w;
    w.cmd  = cmd;
    w.pos  = pos[POS_W-1:0];
    w.endp = endp[END_W-1:0];
    w.val  = val;
    pending_cmds.push_back(w);
  endtask

  // Mostly in-range words with random content, the rest raw noise.
  task automatic add_random_cmds(int unsigned count);
    tree_cmd_t   w;
    int unsigned n;
    n = (leaves_cfg > LEAVES_DEF) ? LEAVES_DEF : leaves_cfg;
    for (int i = 0; i < count; i++) begin
      w.cmd = 1'($urandom_range(1));
      if (n != 0 && $urandom_range(9) < 8) w.pos = POS_W'($urandom_range(n - 1));
      else w.pos = POS_W'($urandom);
      if ($urandom_range(9) < 8 && w.pos <= n) w.endp = END_W'($urandom_range(n, w.pos));
      else w.endp = END_W'($urandom);
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(3))
          0: w.val = 32'h8000_0000;
          1: w.val = 32'h7fff_ffff;
          2: w.val = 32'hffff_ffff;
          default: w.val = '0;
        endcase
      end else begin
        w.val = $urandom;
      end
      pending_cmds.push_back(w);
    end
  endtask

  // Hold until every word is taken and answered, then let the unit settle.
  task automatic drain();
    do @(negedge clk_i);
    while (pending_cmds.size() != 0 || start || sum_expect_q.size() != 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_leaves(logic [CFG_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Driver: advance to the next word once the current one is taken.
  always @(posedge clk_i) begin
    if (rst_ni && (!start || !busy)) begin
      if (pending_cmds.size() != 0 &&
          ((words_sent >= 400 && words_sent < 700) || $urandom_range(99) >= 9)) begin
        tree_cmd_t w;
        w = pending_cmds.pop_front();
        start          <= 1'b1;
        cmd_i          <= w.cmd;
        position_i     <= w.pos;
        end_position_i <= w.endp;
        leaf_value_i   <= w.val;
        words_sent++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check results, then track config writes and accepted words.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        if (sum_expect_q.size() == 0) begin
          report_mismatch("unexpected result word, sum", range_sum_o, '0);
        end else begin
          tree_result_t e;
          e = sum_expect_q.pop_front();
          if (range_sum_o !== e.sum) report_mismatch("range_sum", range_sum_o, e.sum);
          if (error_o !== e.err)
            report_mismatch("error", DATA_W'(error_o), DATA_W'(e.err));
        end
      end
      if (cfg_we_i) leaves_cfg = cfg_wdata_i;
      if (start && busy === 1'b0) begin
        tree_cmd_t w;
        w.cmd  = cmd_i;
        w.pos  = position_i;
        w.endp = end_position_i;
        w.val  = leaf_value_i;
        sum_expect_q.push_back(apply_tree_cmd(w));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("segment_tree_range_sum_unit: mismatch");
      $finish;
    end
  end

  initial begin
    int unsigned leaf_plan [9];
    int unsigned word_plan [9];
    leaf_plan = '{1, 2, 0, 2047, 7, 1025, 100, 1023, 1024};
    word_plan = '{60, 60, 30, 200, 150, 100, 200, 200, 200};
    foreach (tree_model[i]) tree_model[i] = '0;
    leaves_cfg = LEAVES_RESET;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, wrap, empty intervals and rejected commands.
    add_cmd(CMD_QUERY, 0, 1024, '0);
    add_cmd(CMD_SET, 0, 0, 32'h7fff_ffff);
    add_cmd(CMD_SET, 1, 2047, 32'h0000_0001);
    add_cmd(CMD_SET, 1023, 0, 32'h8000_0000);
    add_cmd(CMD_SET, 512, 0, 32'hffff_ffff);
    add_cmd(CMD_QUERY, 0, 2, '0);
    add_cmd(CMD_QUERY, 0, 1024, 32'hffff_ffff);
    add_cmd(CMD_QUERY, 1023, 1024, '0);
    add_cmd(CMD_QUERY, 5, 5, '0);
    add_cmd(CMD_QUERY, 1023, 1023, '0);
    add_cmd(CMD_QUERY, 0, 0, '0);
    add_cmd(CMD_QUERY, 10, 3, '0);
    add_cmd(CMD_QUERY, 0, 1025, '0);
    add_cmd(CMD_QUERY, 1023, 2047, '0);
    add_cmd(CMD_SET, 1023, 0, 32'h1234_5678);
    add_cmd(CMD_QUERY, 511, 513, '0);
    add_cmd(CMD_QUERY, 0, 1023, '0);
    add_cmd(CMD_QUERY, 512, 1024, '0);
    add_random_cmds(270);
    drain();

    foreach (leaf_plan[p]) begin
      write_leaves(leaf_plan[p][CFG_W-1:0]);
      @(negedge clk_i);
      add_cmd(CMD_QUERY, 0, leaf_plan[p], '0);
      add_cmd(CMD_SET, leaf_plan[p] - 1, 0, $urandom);
      add_random_cmds(word_plan[p]);
      drain();
    end

    if (mismatch_cnt == 0) begin
      $display("segment_tree_range_sum_unit: match");
    end else begin
      $display("segment_tree_range_sum_unit: mismatch");
    end
    $finish;
  end

endmodule

// ----- segment_tree_range_sum_unit.f -----
rtl/segt_pkg.sv
rtl/segt_ctrl.sv
rtl/segt_dpath.sv
rtl/segment_tree_range_sum_unit.sv
test/segment_tree_range_sum_unit_tb.sv
